// ===== src/prs_pkg.sv =====
package prs_pkg;

	// Rail modes as stored and as reported in the packed state field.
	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_SETTLING = 2'd1,
		MODE_ON       = 2'd2,
		MODE_SHED     = 2'd3
	} rail_mode_t;

	// Command codes of an input item.
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHED_TABLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORE_TABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TABLE  = 2'd3;
	localparam int CFG_DATA_W = 64;

	// Input item payload.
	typedef struct packed {
		logic        command;
		logic [31:0] now_ms;
		logic [15:0] battery_mv;
		logic [2:0]  rail_index;
		logic        want_on;
	} in_item_t;

	// Result item payload.
	typedef struct packed {
		logic [3:0]  rail_enables;
		logic [7:0]  rail_states;
		logic        all_settled;
		logic [31:0] shed_total;
		logic [31:0] restore_total;
		logic        config_error;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic walk;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] n_active;
	} dp_status_t;

	// One 16-bit entry of a four-entry table, entry 0 in the low bits.
	function automatic logic [15:0] tbl_entry(input logic [63:0] tbl, input logic [1:0] idx);
		tbl_entry = tbl[{idx, 4'b0000} +: 16];
	endfunction

endpackage

// ===== src/prs_if.sv =====
// Input channel carrying tick and request items.
interface prs_in_if;
	logic               valid;
	logic               ready;
	prs_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Output channel carrying result items.
interface prs_out_if;
	logic               valid;
	logic               ready;
	prs_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/power_rail_sequencer_with_shedding_unit.sv =====
// Power rail sequencer with load shedding for up to four rails. Configure it through the
// write port while it is idle, then send request items (set a rail's wanted flag) and tick
// items (time and battery voltage). Every item produces exactly one result with the rail
// enables, packed rail states, settled flag, shed and restore totals and a threshold
// configuration error flag. An accepted request goes straight to the finish state; a tick
// first walks the active rails one per cycle through a single shared rail update unit.
// Items are processed one at a time; a finished result waits in an output register, so the
// next item can be accepted and worked on before the previous result has been taken.
module power_rail_sequencer_with_shedding_unit #(
	parameter int RAIL_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prs_pkg::CFG_DATA_W-1:0]  cfg_data,
	prs_in_if.sink                          in_ch,
	prs_out_if.source                       out_ch
);

	localparam int IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;

	prs_pkg::dp_cmd_t    cmd;
	prs_pkg::dp_status_t status;
	logic [IDX_W-1:0]    rail_sel;
	logic                in_ready;
	logic                out_valid;
	prs_pkg::out_item_t  out_data;

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.data  = out_data;

	// Sequencing controller.
	prs_ctrl #(
		.RAIL_COUNT(RAIL_COUNT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.data.command),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ch.ready),
		.status     (status),
		.cmd        (cmd),
		.rail_sel   (rail_sel)
	);

	// Rail state, configuration and result datapath.
	prs_dp #(
		.RAIL_COUNT(RAIL_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.rail_sel  (rail_sel),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// ===== src/prs_ctrl.sv =====
module prs_ctrl #(
	parameter int RAIL_COUNT = 4,
	localparam int IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_command,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  prs_pkg::dp_status_t  status,
	output prs_pkg::dp_cmd_t     cmd,
	output logic [IDX_W-1:0]     rail_sel
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] rail_q;
	logic             out_valid_q;
	logic             accept;
	logic             load_out;
	logic             last_rail;

	// A transaction is taken only while no item is in progress.
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign last_rail = ({{(3 - IDX_W){1'b0}}, rail_q} == (status.n_active - 3'd1));

	assign cmd.accept   = accept;
	assign cmd.walk     = (state_q == ST_WALK);
	assign cmd.load_out = load_out;
	assign rail_sel     = rail_q;
	assign out_valid    = out_valid_q;

	// Sequencer state, rail pointer and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rail_q <= '0;
						if (in_command == prs_pkg::CMD_TICK && status.n_active != 3'd0) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					if (last_rail) begin
						state_q <= ST_FINISH;
					end else begin
						rail_q <= rail_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/prs_dp.sv =====
module prs_dp #(
	parameter int RAIL_COUNT = 4,
	localparam int IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [prs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [prs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  prs_pkg::in_item_t                    in_data,
	input  prs_pkg::dp_cmd_t                     cmd,
	input  logic [IDX_W-1:0]                     rail_sel,
	output prs_pkg::dp_status_t                  status,
	output prs_pkg::out_item_t                   out_data
);

	localparam logic [2:0] RAIL_LIMIT = 3'(RAIL_COUNT);

	// Configuration registers.
	logic [2:0]  rail_count_q;
	logic [63:0] shed_tbl_q;
	logic [63:0] restore_tbl_q;
	logic [63:0] settle_tbl_q;

	// Rail state and event counters.
	prs_pkg::rail_mode_t mode_q [RAIL_COUNT];
	logic [31:0]         lct_q [RAIL_COUNT];
	logic [RAIL_COUNT-1:0] wanted_q;
	logic [31:0]         shed_cnt_q;
	logic [31:0]         restore_cnt_q;

	// Latched tick operands and the one-settling-rail flag.
	logic [31:0] now_q;
	logic [15:0] batt_q;
	logic        busy_q;

	prs_pkg::out_item_t out_q;

	logic [2:0]  n_active;
	logic [15:0] shed_thr;
	logic [15:0] rest_thr;
	logic [15:0] settle_t;
	logic [31:0] elapsed;

	// Next values from the rail update unit.
	prs_pkg::rail_mode_t mode_nx;
	logic                lct_load;
	logic                busy_nx;
	logic                shed_ev;
	logic                restore_ev;

	prs_pkg::out_item_t  report;

	assign n_active      = (rail_count_q > RAIL_LIMIT) ? RAIL_LIMIT : rail_count_q;
	assign status.n_active = n_active;
	assign out_data      = out_q;

	assign shed_thr = prs_pkg::tbl_entry(shed_tbl_q, 2'(rail_sel));
	assign rest_thr = prs_pkg::tbl_entry(restore_tbl_q, 2'(rail_sel));
	assign settle_t = prs_pkg::tbl_entry(settle_tbl_q, 2'(rail_sel));
	assign elapsed  = now_q - lct_q[rail_sel];

	// Update of the selected rail for one step of the tick walk.
	always_comb begin
		prs_pkg::rail_mode_t m;
		logic                done;
		logic                wanted;
		m          = mode_q[rail_sel];
		wanted     = wanted_q[rail_sel];
		busy_nx    = busy_q;
		lct_load   = 1'b0;
		shed_ev    = 1'b0;
		restore_ev = 1'b0;
		done       = 1'b0;

		if (m == prs_pkg::MODE_SETTLING) begin
			if (elapsed >= {16'd0, settle_t}) begin
				m = prs_pkg::MODE_ON;
			end else begin
				busy_nx = 1'b1;
			end
		end

		if (shed_thr != 16'd0 && (m == prs_pkg::MODE_ON || m == prs_pkg::MODE_SETTLING)
				&& batt_q < shed_thr) begin
			m        = prs_pkg::MODE_SHED;
			lct_load = 1'b1;
			shed_ev  = 1'b1;
			done     = 1'b1;
		end else if (m == prs_pkg::MODE_SHED) begin
			if (batt_q >= rest_thr && wanted) begin
				m          = prs_pkg::MODE_OFF;
				restore_ev = 1'b1;
			end else begin
				done = 1'b1;
			end
		end

		if (!done) begin
			if (wanted && m == prs_pkg::MODE_OFF) begin
				// A rail starts only when no rail walked earlier in this tick is settling and the battery allows it.
				if (!busy_nx && !(shed_thr != 16'd0 && batt_q < rest_thr)) begin
					m        = (settle_t != 16'd0) ? prs_pkg::MODE_SETTLING : prs_pkg::MODE_ON;
					lct_load = 1'b1;
					busy_nx  = (settle_t != 16'd0);
				end
			end else if (!wanted && (m == prs_pkg::MODE_ON || m == prs_pkg::MODE_SETTLING)) begin
				m        = prs_pkg::MODE_OFF;
				lct_load = 1'b1;
			end
		end
		mode_nx = m;
	end

	// Result fields from the state after the update.
	always_comb begin
		logic [3:0] en;
		logic [7:0] st;
		logic       settled;
		logic       cerr;
		logic [15:0] s_thr;
		logic [15:0] r_thr;
		en      = '0;
		st      = '0;
		settled = 1'b1;
		cerr    = 1'b0;
		for (int i = 0; i < RAIL_COUNT; i++) begin
			s_thr = prs_pkg::tbl_entry(shed_tbl_q, 2'(i));
			r_thr = prs_pkg::tbl_entry(restore_tbl_q, 2'(i));
			if (3'(i) < n_active) begin
				if (mode_q[i] == prs_pkg::MODE_ON || mode_q[i] == prs_pkg::MODE_SETTLING) begin
					en[i] = 1'b1;
				end
				st[2*i +: 2] = mode_q[i];
				if ((wanted_q[i] != (mode_q[i] == prs_pkg::MODE_ON))
						&& mode_q[i] != prs_pkg::MODE_SHED) begin
					settled = 1'b0;
				end
				if (s_thr != 16'd0 && r_thr <= s_thr) begin
					cerr = 1'b1;
				end
			end
		end
		report.rail_enables  = en;
		report.rail_states   = st;
		report.all_settled   = settled;
		report.shed_total    = shed_cnt_q;
		report.restore_total = restore_cnt_q;
		report.config_error  = cerr;
	end

	// Configuration registers and rail state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_count_q  <= '0;
			shed_tbl_q    <= '0;
			restore_tbl_q <= '0;
			settle_tbl_q  <= '0;
			wanted_q      <= '0;
			shed_cnt_q    <= '0;
			restore_cnt_q <= '0;
			busy_q        <= 1'b0;
			for (int i = 0; i < RAIL_COUNT; i++) begin
				mode_q[i] <= prs_pkg::MODE_OFF;
				lct_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					prs_pkg::REG_RAIL_COUNT:    rail_count_q  <= cfg_data[2:0];
					prs_pkg::REG_SHED_TABLE:    shed_tbl_q    <= cfg_data;
					prs_pkg::REG_RESTORE_TABLE: restore_tbl_q <= cfg_data;
					prs_pkg::REG_SETTLE_TABLE:  settle_tbl_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				busy_q <= 1'b0;
				if (in_data.command == prs_pkg::CMD_REQUEST && in_data.rail_index < n_active) begin
					wanted_q[in_data.rail_index[IDX_W-1:0]] <= in_data.want_on;
				end
			end
			if (cmd.walk) begin
				mode_q[rail_sel] <= mode_nx;
				busy_q           <= busy_nx;
				if (lct_load) begin
					lct_q[rail_sel] <= now_q;
				end
				if (shed_ev) begin
					shed_cnt_q <= shed_cnt_q + 32'd1;
				end
				if (restore_ev) begin
					restore_cnt_q <= restore_cnt_q + 32'd1;
				end
			end
		end
	end

	// Tick operands and the result register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q  <= in_data.now_ms;
			batt_q <= in_data.battery_mv;
		end
		if (cmd.load_out) begin
			out_q <= report;
		end
	end

endmodule
